>>> rtl/svrm_pkg.sv
// Package for the sample voice resampler/mixer: constants, register
// indexes, sequencer states and the request/response types of the shared ALU.
// No dependencies.
package svrm_pkg;

  localparam int FractionBits = 14;
  localparam int AddressBits  = 17;
  localparam int PosBits      = 31;

  localparam logic [PosBits-1:0] OneSample = PosBits'(1) << FractionBits;
  localparam logic [7:0]         FullPan   = 8'd255;

  // register indexes on the config port (byte address / 4)
  localparam logic [2:0] RegStep       = 3'd0;
  localparam logic [2:0] RegAmplitude  = 3'd1;
  localparam logic [2:0] RegPanning    = 3'd2;
  localparam logic [2:0] RegLoopStart  = 3'd3;
  localparam logic [2:0] RegLoopLength = 3'd4;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_DCHK,
    S_DIV,
    S_ADD,
    S_WL,
    S_WR,
    S_PL,
    S_PR,
    S_STEP,
    S_FINISH
  } state_e;

  // operands for the shared adder/subtractor and multiplier
  typedef struct packed {
    logic               inv;
    logic [31:0]        a;
    logic [31:0]        b;
    logic signed [17:0] ma;
    logic signed [8:0]  mb;
  } alu_req_t;

  typedef struct packed {
    logic [32:0]        sum;
    logic signed [26:0] prod;
  } alu_rsp_t;

endpackage

>>> rtl/svrm_alu.sv
// Shared arithmetic unit of the voice: one 32-bit add/subtract with carry
// out (carry set on subtract means a >= b) and one 18x9 signed multiplier.
// Depends on svrm_pkg.
module svrm_alu
  import svrm_pkg::*;
(
  input  alu_req_t req_i,
  output alu_rsp_t rsp_o
);

  logic [31:0] b_eff;

  assign b_eff      = req_i.inv ? ~req_i.b : req_i.b;
  assign rsp_o.sum  = {1'b0, req_i.a} + {1'b0, b_eff} + {32'd0, req_i.inv};
  assign rsp_o.prod = 27'(req_i.ma * req_i.mb);

endmodule

>>> rtl/sample_voice_resampler_mixer.sv
// One sample-playback voice: a mix item mixes the current sample into the left/right
// accumulators and advances the fixed-point position; a set item loads the position.
// Depends on svrm_pkg and svrm_alu.
// Either item wraps or ends at the loop end; a wrap reduces the overshoot modulo the
// loop length, by bit-serial remainder on the shared subtractor once it reaches a full
// loop length. A new request is taken only after the previous result is issued.
// Reset: config registers, state, position and output valid clear to zero, asynchronously.
module sample_voice_resampler_mixer
  import svrm_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // stream in
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [7:0] sample_value, [38:8] start_position, [54:39] left_in,
  // [70:55] right_in, [71] zero
  input  logic [71:0] s_axis_tdata,
  // [0] op
  input  logic [0:0]  s_axis_tuser,
  // stream out
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [15:0] left_out, [31:16] right_out, [48:32] fetch_address, [49] ended,
  // [55:50] zero
  output logic [55:0] m_axis_tdata,
  // config port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // config registers
  logic [19:0]        step_q;
  logic [7:0]         amp_q, pan_q;
  logic [PosBits-1:0] loop_begin_q, loop_len_q;
  logic [31:0]        loop_end;
  logic               one_shot;

  // sequencer and datapath
  state_e             state_q, state_d;
  logic [PosBits-1:0] position_q, position_d;
  logic [31:0]        p_q, p_d;
  logic [31:0]        d_q, d_d;
  logic [PosBits-1:0] r_q, r_d;
  logic [4:0]         cnt_q, cnt_d;
  logic               post_q, post_d;
  logic               done_q, done_d;
  logic [15:0]        wl_q, wl_d, wr_q, wr_d;
  logic signed [7:0]  sample_q, sample_d;
  logic [15:0]        left_q, left_d, right_q, right_d;
  logic [31:0]        t_div;
  logic               ge;

  logic               m_valid_q, m_valid_d;
  logic [55:0]        m_data_q, m_data_d;
  logic [PosBits-1:0] pos_shift;

  alu_req_t           req;
  alu_rsp_t           rsp;

  svrm_alu u_alu (
    .req_i (req),
    .rsp_o (rsp)
  );

  // config port
  logic cfg_wr;
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q       <= '0;
      amp_q        <= '0;
      pan_q        <= '0;
      loop_begin_q <= '0;
      loop_len_q   <= '0;
    end else if (cfg_wr) begin
      case (paddr[4:2])
        RegStep:       step_q       <= pwdata[19:0];
        RegAmplitude:  amp_q        <= pwdata[7:0];
        RegPanning:    pan_q        <= pwdata[7:0];
        RegLoopStart:  loop_begin_q <= pwdata[PosBits-1:0];
        RegLoopLength: loop_len_q   <= pwdata[PosBits-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      RegStep:       prdata = {12'd0, step_q};
      RegAmplitude:  prdata = {24'd0, amp_q};
      RegPanning:    prdata = {24'd0, pan_q};
      RegLoopStart:  prdata = {1'b0, loop_begin_q};
      RegLoopLength: prdata = {1'b0, loop_len_q};
      default:       prdata = '0;
    endcase
  end

  assign loop_end = {1'b0, loop_begin_q} + {1'b0, loop_len_q};
  assign one_shot = (loop_len_q <= OneSample);
  assign ge       = rsp.sum[32];
  assign t_div    = {r_q, d_q[cnt_q]};
  assign pos_shift = position_q >> FractionBits;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      position_q <= '0;
      m_valid_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      position_q <= position_d;
      m_valid_q  <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    p_q      <= p_d;
    d_q      <= d_d;
    r_q      <= r_d;
    cnt_q    <= cnt_d;
    post_q   <= post_d;
    done_q   <= done_d;
    wl_q     <= wl_d;
    wr_q     <= wr_d;
    sample_q <= sample_d;
    left_q   <= left_d;
    right_q  <= right_d;
    m_data_q <= m_data_d;
  end

  always_comb begin
    state_d    = state_q;
    position_d = position_q;
    p_d        = p_q;
    d_d        = d_q;
    r_d        = r_q;
    cnt_d      = cnt_q;
    post_d     = post_q;
    done_d     = done_q;
    wl_d       = wl_q;
    wr_d       = wr_q;
    sample_d   = sample_q;
    left_d     = left_q;
    right_d    = right_q;
    m_data_d   = m_data_q;
    m_valid_d  = m_valid_q & ~m_axis_tready;
    req        = '0;
    s_axis_tready = 1'b0;

    case (state_q)
      S_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          sample_d = s_axis_tdata[7:0];
          left_d   = s_axis_tdata[54:39];
          right_d  = s_axis_tdata[70:55];
          p_d      = s_axis_tuser[0] ? {1'b0, s_axis_tdata[38:8]} : {1'b0, position_q};
          post_d   = s_axis_tuser[0];
          done_d   = 1'b0;
          state_d  = S_CHECK;
        end
      end
      // compare against the loop end
      S_CHECK: begin
        req.inv = 1'b1;
        req.a   = p_q;
        req.b   = loop_end;
        if (!ge) begin
          if (post_q) begin
            position_d = p_q[PosBits-1:0];
            state_d    = S_FINISH;
          end else begin
            state_d = S_WL;
          end
        end else if (one_shot) begin
          position_d = loop_end[PosBits-1:0];
          done_d     = 1'b1;
          state_d    = S_FINISH;
        end else begin
          d_d     = rsp.sum[31:0];
          state_d = S_DCHK;
        end
      end
      // overshoot below one loop length needs no division
      S_DCHK: begin
        req.inv = 1'b1;
        req.a   = d_q;
        req.b   = {1'b0, loop_len_q};
        if (!ge) begin
          r_d     = d_q[PosBits-1:0];
          state_d = S_ADD;
        end else begin
          r_d     = '0;
          cnt_d   = 5'd31;
          state_d = S_DIV;
        end
      end
      // restoring remainder, one bit per cycle
      S_DIV: begin
        req.inv = 1'b1;
        req.a   = t_div;
        req.b   = {1'b0, loop_len_q};
        r_d     = ge ? rsp.sum[PosBits-1:0] : t_div[PosBits-1:0];
        cnt_d   = cnt_q - 5'd1;
        if (cnt_q == 5'd0) begin
          state_d = S_ADD;
        end
      end
      // wrapped position = loop begin + (overshoot mod length)
      S_ADD: begin
        req.a      = {1'b0, loop_begin_q};
        req.b      = {1'b0, r_q};
        position_d = rsp.sum[PosBits-1:0];
        state_d    = post_q ? S_FINISH : S_WL;
      end
      S_WL: begin
        req.ma  = {10'd0, amp_q};
        req.mb  = {1'b0, FullPan - pan_q};
        wl_d    = rsp.prod[15:0];
        state_d = S_WR;
      end
      S_WR: begin
        req.ma  = {10'd0, amp_q};
        req.mb  = {1'b0, pan_q};
        wr_d    = rsp.prod[15:0];
        state_d = S_PL;
      end
      // floor((sample * weight) / 256), 16-bit wrap
      S_PL: begin
        req.ma  = {2'd0, wl_q};
        req.mb  = {sample_q[7], sample_q};
        left_d  = left_q + rsp.prod[23:8];
        state_d = S_PR;
      end
      S_PR: begin
        req.ma  = {2'd0, wr_q};
        req.mb  = {sample_q[7], sample_q};
        right_d = right_q + rsp.prod[23:8];
        state_d = S_STEP;
      end
      S_STEP: begin
        req.a   = {1'b0, position_q};
        req.b   = {12'd0, step_q};
        p_d     = rsp.sum[31:0];
        post_d  = 1'b1;
        state_d = S_CHECK;
      end
      S_FINISH: begin
        if (!m_valid_q || m_axis_tready) begin
          m_data_d  = {6'd0, done_q, pos_shift[AddressBits-1:0], right_q, left_q};
          m_valid_d = 1'b1;
          state_d   = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

endmodule

>>> rtl/svrm_checker.sv
// Port-level checker for sample_voice_resampler_mixer, attached by bind.
// Depends on the top level's port list only.
module svrm_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [55:0] m_axis_tdata,
  input logic        pready
);

  logic s_req;
  assign s_req = s_axis_tvalid & s_axis_tready;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  // one request at a time: busy right after taking one
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_req |=> !s_axis_tready)
    else $error("ready right after a request");

  // no result appears on the cycle right after a request
  a_min_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> !$past(s_req))
    else $error("result too early");

  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pready)
    else $error("pready low");

endmodule

bind sample_voice_resampler_mixer svrm_checker u_svrm_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .pready        (pready)
);
